[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker file rmcv_checker.sv.
// Clock clk and active-low reset rst_n are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/rmcv_pkg.sv]
// Shared types and codes of the register-mode CV programming sequencer.
// No dependencies; used by the sequencer core, the top level and the checker.
package rmcv_pkg;

  localparam logic [2:0] OP_DONE       = 3'd0;
  localparam logic [2:0] OP_READ_BYTE  = 3'd1;
  localparam logic [2:0] OP_WRITE_BYTE = 3'd2;
  localparam logic [2:0] OP_READ_BIT   = 3'd3;
  localparam logic [2:0] OP_WRITE_BIT  = 3'd4;
  localparam logic [2:0] OP_VERIFY     = 3'd5;
  localparam logic [2:0] OP_FACTORY    = 3'd6;

  localparam logic [2:0] RES_SUCCESS     = 3'd0;
  localparam logic [2:0] RES_ERROR       = 3'd1;
  localparam logic [2:0] RES_BUSY        = 3'd2;
  localparam logic [2:0] RES_VERIFY_FAIL = 3'd3;
  localparam logic [2:0] RES_NO_ACK      = 3'd4;

  localparam logic [1:0] PROG_READ   = 2'd0;
  localparam logic [1:0] PROG_WRITE  = 2'd1;
  localparam logic [1:0] PROG_VERIFY = 2'd2;

  localparam logic [10:0] CV_CONFIG        = 11'd29;
  localparam logic [10:0] CV_ACC_ADDR_LOW  = 11'd513;
  localparam logic [10:0] CV_ACC_ADDR_HIGH = 11'd520;
  localparam logic [7:0]  SCAN_LAST        = 8'd255;
  localparam logic [3:0]  RESET_REG        = 4'd8;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [10:0] cv_num;
    logic        decoder_is_accessory;
    logic [7:0]  data_value;
    logic [3:0]  bit_pos;
    logic        bit_val;
    logic        primitive_ack;
    logic        primitive_refuses;
  } item_t;

  typedef struct packed {
    logic        start_accepted;
    logic        issue_command;
    logic        command_is_write;
    logic [3:0]  command_register;
    logic [7:0]  command_value;
    logic        progress_valid;
    logic [1:0]  progress_phase;
    logic [7:0]  progress_step;
    logic        done_res;
    logic [2:0]  done_result;
    logic [7:0]  done_value;
  } result_t;

endpackage

[hdl/rmcv_seq.sv]
// Sequencer core: operation state and the decode of one item into one result.
// Depends on rmcv_pkg. State advances only on an accepted item.
module rmcv_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  rmcv_pkg::item_t  item,
  output rmcv_pkg::result_t res
);
  import rmcv_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE          = 4'd0,
    PH_READ_CV       = 4'd1,
    PH_WRITE_CV      = 4'd2,
    PH_WRITE_CV_VFY  = 4'd3,
    PH_READ_BIT      = 4'd4,
    PH_WBIT_READ     = 4'd5,
    PH_WBIT_WRITE    = 4'd6,
    PH_WBIT_VERIFY   = 4'd7,
    PH_FACTORY       = 4'd8,
    PH_VERIFY_VALUE  = 4'd9
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  target_r, target_nxt;
  logic [2:0]  bit_index_r, bit_index_nxt;
  logic        bit_to_write_r, bit_to_write_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  cand_r, cand_nxt;
  logic [7:0]  step_r, step_nxt;

  logic [3:0]  reg_sel;
  logic        bit_bad;
  logic [7:0]  bit_mask;

  function automatic logic [3:0] map_cv(input logic [10:0] cv, input logic acc);
    logic [3:0] r;
    r = 4'd0;
    if (!acc) begin
      if (cv >= 11'd1 && cv <= 11'd4) r = cv[3:0];
      else if (cv == CV_CONFIG) r = 4'd5;
      else if (cv == 11'd7) r = 4'd7;
      else if (cv == 11'd8) r = 4'd8;
    end else begin
      if (cv == CV_ACC_ADDR_LOW) r = 4'd1;
      else if (cv == 11'd7) r = 4'd7;
      else if (cv == CV_ACC_ADDR_HIGH) r = 4'd8;
    end
    return r;
  endfunction

  always_comb begin
    phase_nxt        = phase_r;
    target_nxt       = target_r;
    bit_index_nxt    = bit_index_r;
    bit_to_write_nxt = bit_to_write_r;
    held_nxt         = held_r;
    cand_nxt         = cand_r;
    step_nxt         = step_r;
    res              = '0;
    reg_sel  = map_cv(item.cv_num, item.decoder_is_accessory);
    bit_bad  = (item.opcode inside {OP_READ_BIT, OP_WRITE_BIT}) && (item.bit_pos > 4'd7);
    bit_mask = 8'd1 << bit_index_r;

    case (item.opcode)
      OP_DONE: begin
        case (phase_r)
          PH_READ_CV, PH_READ_BIT, PH_WBIT_READ: begin
            step_nxt           = step_r + 8'd1;
            res.progress_valid = 1'b1;
            res.progress_phase = PROG_READ;
            res.progress_step  = step_r + 8'd1;
            if (item.primitive_ack) begin
              if (phase_r == PH_WBIT_READ) begin
                held_nxt  = bit_to_write_r ? (cand_r | bit_mask) : (cand_r & ~bit_mask);
                phase_nxt = PH_WBIT_WRITE;
                res.issue_command    = 1'b1;
                res.command_is_write = 1'b1;
                res.command_register = target_r;
                res.command_value    = held_nxt;
                if (item.primitive_refuses) begin
                  phase_nxt       = PH_IDLE;
                  res.done_res    = 1'b1;
                  res.done_result = RES_BUSY;
                end
              end else begin
                phase_nxt       = PH_IDLE;
                res.done_res    = 1'b1;
                res.done_result = RES_SUCCESS;
                res.done_value  = (phase_r == PH_READ_BIT) ?
                                  {7'd0, cand_r[bit_index_r]} : cand_r;
              end
            end else if (cand_r == SCAN_LAST) begin
              phase_nxt       = PH_IDLE;
              res.done_res    = 1'b1;
              res.done_result = RES_ERROR;
            end else begin
              cand_nxt = cand_r + 8'd1;
              res.issue_command    = 1'b1;
              res.command_register = target_r;
              res.command_value    = cand_r + 8'd1;
              if (item.primitive_refuses) begin
                phase_nxt       = PH_IDLE;
                res.done_res    = 1'b1;
                res.done_result = RES_BUSY;
              end
            end
          end
          PH_WRITE_CV, PH_WBIT_WRITE: begin
            if (phase_r == PH_WRITE_CV) begin
              step_nxt           = step_r + 8'd1;
              res.progress_valid = 1'b1;
              res.progress_phase = PROG_WRITE;
              res.progress_step  = step_r + 8'd1;
            end
            // the write's own ACK is ignored: the verify decides
            phase_nxt = (phase_r == PH_WRITE_CV) ? PH_WRITE_CV_VFY : PH_WBIT_VERIFY;
            res.issue_command    = 1'b1;
            res.command_register = target_r;
            res.command_value    = held_r;
            if (item.primitive_refuses) begin
              phase_nxt       = PH_IDLE;
              res.done_res    = 1'b1;
              res.done_result = RES_BUSY;
            end
          end
          PH_WRITE_CV_VFY: begin
            step_nxt           = step_r + 8'd1;
            res.progress_valid = 1'b1;
            res.progress_phase = PROG_VERIFY;
            res.progress_step  = step_r + 8'd1;
            phase_nxt          = PH_IDLE;
            res.done_res       = 1'b1;
            res.done_result    = item.primitive_ack ? RES_SUCCESS : RES_VERIFY_FAIL;
            res.done_value     = held_r;
          end
          PH_WBIT_VERIFY: begin
            phase_nxt       = PH_IDLE;
            res.done_res    = 1'b1;
            res.done_result = item.primitive_ack ? RES_SUCCESS : RES_VERIFY_FAIL;
            res.done_value  = {7'd0, bit_to_write_r};
          end
          PH_FACTORY: begin
            phase_nxt       = PH_IDLE;
            res.done_res    = 1'b1;
            res.done_result = item.primitive_ack ? RES_SUCCESS : RES_NO_ACK;
          end
          PH_VERIFY_VALUE: begin
            phase_nxt       = PH_IDLE;
            res.done_res    = 1'b1;
            res.done_result = item.primitive_ack ? RES_SUCCESS : RES_VERIFY_FAIL;
            res.done_value  = held_r;
          end
          default: begin
          end
        endcase
      end
      OP_FACTORY: begin
        if (phase_r == PH_IDLE) begin
          step_nxt  = 8'd0;
          phase_nxt = item.primitive_refuses ? PH_IDLE : PH_FACTORY;
          res.start_accepted   = ~item.primitive_refuses;
          res.issue_command    = 1'b1;
          res.command_is_write = 1'b1;
          res.command_register = RESET_REG;
          res.command_value    = {4'd0, RESET_REG};
        end
      end
      OP_READ_BYTE, OP_WRITE_BYTE, OP_READ_BIT, OP_WRITE_BIT, OP_VERIFY: begin
        if (!bit_bad && reg_sel != 4'd0 && phase_r == PH_IDLE) begin
          target_nxt = reg_sel;
          step_nxt   = 8'd0;
          res.issue_command    = 1'b1;
          res.command_register = reg_sel;
          if (item.opcode inside {OP_WRITE_BYTE, OP_VERIFY}) begin
            held_nxt  = item.data_value;
            phase_nxt = (item.opcode == OP_WRITE_BYTE) ? PH_WRITE_CV : PH_VERIFY_VALUE;
            res.command_is_write = (item.opcode == OP_WRITE_BYTE);
            res.command_value    = item.data_value;
          end else begin
            cand_nxt = 8'd0;
            if (item.opcode != OP_READ_BYTE) bit_index_nxt = item.bit_pos[2:0];
            if (item.opcode == OP_WRITE_BIT) bit_to_write_nxt = item.bit_val;
            phase_nxt = (item.opcode == OP_READ_BYTE) ? PH_READ_CV :
                        (item.opcode == OP_READ_BIT)  ? PH_READ_BIT : PH_WBIT_READ;
          end
          // refused start: loaded fields keep their new values, block stays idle
          if (item.primitive_refuses) phase_nxt = PH_IDLE;
          res.start_accepted = ~item.primitive_refuses;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      target_r       <= 4'd0;
      bit_index_r    <= 3'd0;
      bit_to_write_r <= 1'b0;
      held_r         <= 8'd0;
      cand_r         <= 8'd0;
      step_r         <= 8'd0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      target_r       <= target_nxt;
      bit_index_r    <= bit_index_nxt;
      bit_to_write_r <= bit_to_write_nxt;
      held_r         <= held_nxt;
      cand_r         <= cand_nxt;
      step_r         <= step_nxt;
    end
  end

endmodule

[hdl/register_mode_cv_programming_sequencer_top.sv]
// Register-mode CV programming sequencer, top level.
// Depends on rmcv_pkg and rmcv_seq.
//
// Input channel (in_valid / in_stall): each item is a start command or the
// completion of the last primitive with its ACK outcome. An item is taken at
// a clock edge with in_valid high and in_stall low.
// Result channel (out_valid / out_stall): exactly one result item per input
// item, in order: start outcome, primitive command to drive, progress step and
// the finish report of the operation.
// The result is registered and appears in the cycle after the item is taken;
// one item is taken per cycle while in_stall is low; the whole decode is one
// pass of logic between the sequencer state and the output register.
// Stall: the output register holds a result while out_stall is high; a new
// item is still taken in the cycle the held result leaves. in_stall is high
// only while a result is held and out_stall is high.
// Reset (rst_n low, synchronous): the sequencer returns idle with all its
// operation fields cleared and the output register empty.
module register_mode_cv_programming_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [10:0] in_cv_num,
  input  logic        in_decoder_is_accessory,
  input  logic [7:0]  in_data_value,
  input  logic [3:0]  in_bit_pos,
  input  logic        in_bit_val,
  input  logic        in_primitive_ack,
  input  logic        in_primitive_refuses,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_start_accepted,
  output logic        out_issue_command,
  output logic        out_command_is_write,
  output logic [3:0]  out_command_register,
  output logic [7:0]  out_command_value,
  output logic        out_progress_valid,
  output logic [1:0]  out_progress_phase,
  output logic [7:0]  out_progress_step,
  output logic        out_done_res,
  output logic [2:0]  out_done_result,
  output logic [7:0]  out_done_value
);
  import rmcv_pkg::*;

  item_t   item;
  result_t res;
  result_t res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    accept;

  assign item = '{
    opcode:               in_opcode,
    cv_num:               in_cv_num,
    decoder_is_accessory: in_decoder_is_accessory,
    data_value:           in_data_value,
    bit_pos:              in_bit_pos,
    bit_val:              in_bit_val,
    primitive_ack:        in_primitive_ack,
    primitive_refuses:    in_primitive_refuses
  };

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  rmcv_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (accept),
    .item    (item),
    .res     (res)
  );

  always_comb begin
    if (accept)          out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_start_accepted   = res_r.start_accepted;
  assign out_issue_command    = res_r.issue_command;
  assign out_command_is_write = res_r.command_is_write;
  assign out_command_register = res_r.command_register;
  assign out_command_value    = res_r.command_value;
  assign out_progress_valid   = res_r.progress_valid;
  assign out_progress_phase   = res_r.progress_phase;
  assign out_progress_step    = res_r.progress_step;
  assign out_done_res         = res_r.done_res;
  assign out_done_result      = res_r.done_result;
  assign out_done_value       = res_r.done_value;

endmodule

[hdl/rmcv_checker.sv]
// Port-level checks for the register-mode CV programming sequencer.
// Depends on rmcv_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module rmcv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_start_accepted,
  input logic        out_issue_command,
  input logic        out_done_res,
  input logic [2:0]  out_done_result
);
  import rmcv_pkg::*;

  // a held result survives the stall
  `CHK_NEXT(a_hold, out_valid && out_stall, out_valid)
  // every taken item produces a result in the next cycle
  `CHK_NEXT(a_result, in_valid && !in_stall, out_valid)
  // an accepted start always drives a command and does not finish at once
  `CHK_SAME(a_start, out_valid && out_start_accepted, out_issue_command && !out_done_res)
  // busy only arises from a refused command
  `CHK_SAME(a_busy, out_valid && out_done_res && (out_done_result == RES_BUSY), out_issue_command)

endmodule

bind register_mode_cv_programming_sequencer_top rmcv_checker u_rmcv_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_start_accepted   (out_start_accepted),
  .out_issue_command    (out_issue_command),
  .out_done_res         (out_done_res),
  .out_done_result      (out_done_result)
);

[tb/sequencer_checker.sv]
// Result checker for the register-mode CV programming sequencer: watches both
// channels, predicts each result from its own model of the sequencer and compares.
// Depends on rmcv_pkg for the item and result types and the opcode/result codes.
module sequencer_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  rmcv_pkg::item_t   in_item,
  input  logic              out_valid,
  input  logic              out_stall,
  input  rmcv_pkg::result_t out_item,
  output int                mismatch_count,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import rmcv_pkg::*;

  localparam logic [3:0] MAX_BIT         = 4'd7;
  localparam logic [10:0] CV_VERSION     = 11'd7;
  localparam logic [10:0] CV_MANUFACTURER = 11'd8;
  localparam logic [3:0] REG_ACC_LOW     = 4'd1;
  localparam logic [3:0] REG_CONFIG      = 4'd5;
  localparam logic [3:0] REG_VERSION     = 4'd7;
  localparam logic [3:0] REG_MANUF       = 4'd8;
  localparam logic [3:0] REG_NONE        = 4'd0;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_READ_BYTE,
    SEQ_WRITE_BYTE,
    SEQ_WRITE_BYTE_VERIFY,
    SEQ_READ_BIT,
    SEQ_WBIT_READ,
    SEQ_WBIT_WRITE,
    SEQ_WBIT_VERIFY,
    SEQ_FACTORY,
    SEQ_VERIFY_VALUE
  } seq_phase_e;

  // model of the sequencer state
  seq_phase_e seq_phase;
  logic [3:0] tgt_reg;
  logic [2:0] bit_sel;
  logic       bit_wr;
  logic [7:0] held_val;
  logic [7:0] scan_val;
  logic [7:0] steps;

  result_t expected_results[$];
  result_t want;
  int      result_index;

  function automatic logic [3:0] cv_to_register(input logic [10:0] cv, input logic acc);
    if (!acc) begin
      if (cv >= 11'd1 && cv <= 11'd4) return cv[3:0];
      if (cv == CV_CONFIG) return REG_CONFIG;
      if (cv == CV_VERSION) return REG_VERSION;
      if (cv == CV_MANUFACTURER) return REG_MANUF;
      return REG_NONE;
    end
    if (cv == CV_ACC_ADDR_LOW) return REG_ACC_LOW;
    if (cv == CV_VERSION) return REG_VERSION;
    if (cv == CV_ACC_ADDR_HIGH) return REG_MANUF;
    return REG_NONE;
  endfunction

  // command fields are driven even when the primitive turns it down
  function automatic logic drive_command(inout result_t r, input logic wr,
                                         input logic [3:0] rg, input logic [7:0] val,
                                         input logic refuses);
    r.issue_command    = 1'b1;
    r.command_is_write = wr;
    r.command_register = rg;
    r.command_value    = val;
    return !refuses;
  endfunction

  function automatic void count_step(inout result_t r, input logic [1:0] ph);
    steps            = steps + 8'd1;
    r.progress_valid = 1'b1;
    r.progress_phase = ph;
    r.progress_step  = steps;
  endfunction

  function automatic void finish_op(inout result_t r, input logic [2:0] res,
                                    input logic [7:0] val);
    seq_phase     = SEQ_IDLE;
    r.done_res    = 1'b1;
    r.done_result = res;
    r.done_value  = val;
  endfunction

  function automatic void primitive_done(inout result_t r, input logic ack,
                                         input logic refuses);
    logic [7:0] mask;
    case (seq_phase)
      SEQ_READ_BYTE, SEQ_READ_BIT, SEQ_WBIT_READ: begin
        count_step(r, PROG_READ);
        if (ack) begin
          if (seq_phase == SEQ_WBIT_READ) begin
            mask     = 8'd1 << bit_sel;
            held_val = bit_wr ? (scan_val | mask) : (scan_val & ~mask);
            seq_phase = SEQ_WBIT_WRITE;
            if (!drive_command(r, 1'b1, tgt_reg, held_val, refuses))
              finish_op(r, RES_BUSY, 8'd0);
          end else if (seq_phase == SEQ_READ_BIT) begin
            finish_op(r, RES_SUCCESS, {7'd0, scan_val[bit_sel]});
          end else begin
            finish_op(r, RES_SUCCESS, scan_val);
          end
        end else if (scan_val == SCAN_LAST) begin
          finish_op(r, RES_ERROR, 8'd0);
        end else begin
          scan_val = scan_val + 8'd1;
          if (!drive_command(r, 1'b0, tgt_reg, scan_val, refuses))
            finish_op(r, RES_BUSY, 8'd0);
        end
      end
      SEQ_WRITE_BYTE: begin
        // ack of the write itself is not looked at, the verify decides
        count_step(r, PROG_WRITE);
        seq_phase = SEQ_WRITE_BYTE_VERIFY;
        if (!drive_command(r, 1'b0, tgt_reg, held_val, refuses))
          finish_op(r, RES_BUSY, 8'd0);
      end
      SEQ_WRITE_BYTE_VERIFY: begin
        count_step(r, PROG_VERIFY);
        finish_op(r, ack ? RES_SUCCESS : RES_VERIFY_FAIL, held_val);
      end
      SEQ_WBIT_WRITE: begin
        seq_phase = SEQ_WBIT_VERIFY;
        if (!drive_command(r, 1'b0, tgt_reg, held_val, refuses))
          finish_op(r, RES_BUSY, 8'd0);
      end
      SEQ_WBIT_VERIFY: begin
        finish_op(r, ack ? RES_SUCCESS : RES_VERIFY_FAIL, {7'd0, bit_wr});
      end
      SEQ_FACTORY: begin
        finish_op(r, ack ? RES_SUCCESS : RES_NO_ACK, 8'd0);
      end
      SEQ_VERIFY_VALUE: begin
        finish_op(r, ack ? RES_SUCCESS : RES_VERIFY_FAIL, held_val);
      end
      default: ;
    endcase
  endfunction

  function automatic result_t predict_result(input item_t it);
    result_t r;
    logic [3:0] rg;
    logic ok;
    r  = '0;
    ok = 1'b0;
    case (it.opcode)
      OP_DONE: begin
        primitive_done(r, it.primitive_ack, it.primitive_refuses);
        return r;
      end
      OP_FACTORY: begin
        if (seq_phase != SEQ_IDLE) return r;
        steps     = 8'd0;
        seq_phase = SEQ_FACTORY;
        ok = drive_command(r, 1'b1, RESET_REG, {4'd0, RESET_REG}, it.primitive_refuses);
      end
      OP_READ_BYTE, OP_WRITE_BYTE, OP_READ_BIT, OP_WRITE_BIT, OP_VERIFY: begin
        // bit position is checked before the CV map and the busy test
        if ((it.opcode == OP_READ_BIT || it.opcode == OP_WRITE_BIT) &&
            it.bit_pos > MAX_BIT)
          return r;
        rg = cv_to_register(it.cv_num, it.decoder_is_accessory);
        if (rg == REG_NONE || seq_phase != SEQ_IDLE) return r;
        tgt_reg = rg;
        steps   = 8'd0;
        if (it.opcode == OP_WRITE_BYTE || it.opcode == OP_VERIFY) begin
          held_val  = it.data_value;
          seq_phase = (it.opcode == OP_WRITE_BYTE) ? SEQ_WRITE_BYTE : SEQ_VERIFY_VALUE;
          ok = drive_command(r, it.opcode == OP_WRITE_BYTE, rg, it.data_value,
                             it.primitive_refuses);
        end else begin
          scan_val = 8'd0;
          if (it.opcode != OP_READ_BYTE) bit_sel = it.bit_pos[2:0];
          if (it.opcode == OP_WRITE_BIT) bit_wr = it.bit_val;
          seq_phase = (it.opcode == OP_READ_BYTE) ? SEQ_READ_BYTE :
                      (it.opcode == OP_READ_BIT)  ? SEQ_READ_BIT  : SEQ_WBIT_READ;
          ok = drive_command(r, 1'b0, rg, 8'd0, it.primitive_refuses);
        end
      end
      default: return r;
    endcase
    // a refused first command leaves the loaded fields but returns idle
    if (ok) r.start_accepted = 1'b1;
    else seq_phase = SEQ_IDLE;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic compare_result(input result_t got, input result_t exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("result %0d: got %p, expected %p",
                                result_index, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seq_phase = SEQ_IDLE;
      tgt_reg   = 4'd0;
      bit_sel   = 3'd0;
      bit_wr    = 1'b0;
      held_val  = 8'd0;
      scan_val  = 8'd0;
      steps     = 8'd0;
      expected_results.delete();
      mismatch_count = 0;
      result_index   = 0;
      outstanding <= 0;
    end else begin
      // a result leaving now belongs to an item taken at an earlier edge
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    result_index));
        end else begin
          want = expected_results.pop_front();
          compare_result(out_item, want);
        end
        result_index++;
      end
      if (in_valid && !in_stall) expected_results.push_back(predict_result(in_item));
      outstanding <= expected_results.size();
    end
  end

endmodule

[tb/testbench.sv]
// Top of the sequencer testbench: clock, reset, item stimulus, output stall,
// watchdog and verdict. Depends on rmcv_pkg, the sequencer top and sequencer_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rmcv_pkg::*;

  localparam int         RANDOM_ITEMS   = 1550;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         FULL_SCAN      = 256;
  localparam logic [2:0] OP_UNUSED      = 3'd7;

  logic    clk;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    out_stall = 1'b0;
  logic    quiet     = 1'b0;
  item_t   in_item   = '0;
  logic    in_stall;
  logic    out_valid;
  result_t dut_result;
  int      mismatch_count;
  int      outstanding;
  int      items_sent = 0;
  int      idle_cycles;

  logic       out_start_accepted;
  logic       out_issue_command;
  logic       out_command_is_write;
  logic [3:0] out_command_register;
  logic [7:0] out_command_value;
  logic       out_progress_valid;
  logic [1:0] out_progress_phase;
  logic [7:0] out_progress_step;
  logic       out_done_res;
  logic [2:0] out_done_result;
  logic [7:0] out_done_value;

  register_mode_cv_programming_sequencer_top u_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_opcode               (in_item.opcode),
    .in_cv_num               (in_item.cv_num),
    .in_decoder_is_accessory (in_item.decoder_is_accessory),
    .in_data_value           (in_item.data_value),
    .in_bit_pos              (in_item.bit_pos),
    .in_bit_val              (in_item.bit_val),
    .in_primitive_ack        (in_item.primitive_ack),
    .in_primitive_refuses    (in_item.primitive_refuses),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_start_accepted      (out_start_accepted),
    .out_issue_command       (out_issue_command),
    .out_command_is_write    (out_command_is_write),
    .out_command_register    (out_command_register),
    .out_command_value       (out_command_value),
    .out_progress_valid      (out_progress_valid),
    .out_progress_phase      (out_progress_phase),
    .out_progress_step       (out_progress_step),
    .out_done_res            (out_done_res),
    .out_done_result         (out_done_result),
    .out_done_value          (out_done_value)
  );

  assign dut_result = {out_start_accepted, out_issue_command, out_command_is_write,
                       out_command_register, out_command_value, out_progress_valid,
                       out_progress_phase, out_progress_step, out_done_res,
                       out_done_result, out_done_value};

  sequencer_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (dut_result),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || quiet) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 22);
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL register_mode_cv_programming_sequencer_top");
    $finish;
  end

  function automatic item_t make_item(input logic [2:0] op, input logic [10:0] cv,
                                      input logic acc, input logic [7:0] data,
                                      input logic [3:0] bpos, input logic bval,
                                      input logic ack, input logic refuses);
    item_t it;
    it.opcode               = op;
    it.cv_num               = cv;
    it.decoder_is_accessory = acc;
    it.data_value           = data;
    it.bit_pos              = bpos;
    it.bit_val              = bval;
    it.primitive_ack        = ack;
    it.primitive_refuses    = refuses;
    return it;
  endfunction

  function automatic item_t random_item();
    return make_item(3'($urandom_range(0, 7)), 11'($urandom_range(0, 2047)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // CVs that the chosen decoder map knows
  function automatic logic [10:0] mapped_cv(input logic acc);
    int pick;
    if (acc) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) return CV_ACC_ADDR_LOW;
      if (pick == 1) return 11'd7;
      return CV_ACC_ADDR_HIGH;
    end
    pick = $urandom_range(0, 6);
    if (pick < 4) return 11'(pick + 1);
    if (pick == 4) return CV_CONFIG;
    return 11'(pick + 2);   // CV 7 or 8
  endfunction

  task automatic send_item(input item_t it);
    while (!quiet && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // hold off the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_start(input logic [2:0] op, input logic refuses);
    item_t it;
    it = random_item();
    it.opcode = op;
    if ($urandom_range(0, 99) < 85) it.cv_num = mapped_cv(it.decoder_is_accessory);
    it.bit_pos = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, 7))
                                              : 4'($urandom_range(8, 15));
    it.primitive_refuses = refuses;
    send_item(it);
  endtask

  // a primitive completion; now and then a stray start lands in the middle
  task automatic send_done(input logic ack, input logic clean);
    item_t it;
    if (!clean && $urandom_range(0, 99) < 3)
      send_start(3'($urandom_range(OP_READ_BYTE, OP_FACTORY)), 1'($urandom_range(0, 1)));
    it = random_item();
    it.opcode            = OP_DONE;
    it.primitive_ack     = ack;
    it.primitive_refuses = clean ? 1'b0 : ($urandom_range(0, 99) < 2);
    send_item(it);
  endtask

  task automatic run_operation(input logic full_scan);
    logic [2:0] op;
    int pick;
    int hit;
    pick = $urandom_range(0, 99);
    if (!full_scan && pick < 5) begin
      send_item(random_item());
      return;
    end
    op = full_scan ? OP_READ_BYTE : 3'($urandom_range(OP_READ_BYTE, OP_FACTORY));
    send_start(op, full_scan ? 1'b0 : ($urandom_range(0, 99) < 5));
    case (op)
      OP_READ_BYTE, OP_READ_BIT, OP_WRITE_BIT: begin
        // most scans stop early, a few run long or never get an ack
        pick = $urandom_range(0, 99);
        if (full_scan || pick >= 98) hit = FULL_SCAN;
        else if (pick < 88) hit = $urandom_range(0, 7);
        else hit = $urandom_range(0, 255);
        for (int i = 0; i < hit; i++) send_done(1'b0, full_scan);
        if (hit < FULL_SCAN) send_done(1'b1, 1'b0);
        if (op == OP_WRITE_BIT) begin
          send_done(1'($urandom_range(0, 1)), 1'b0);
          send_done($urandom_range(0, 99) < 70, 1'b0);
        end
      end
      OP_WRITE_BYTE: begin
        send_done(1'($urandom_range(0, 1)), 1'b0);
        send_done($urandom_range(0, 99) < 70, 1'b0);
      end
      default: send_done($urandom_range(0, 99) < 70, 1'b0);
    endcase
  endtask

  initial begin
    int ops;
    int target;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    send_item(make_item(OP_DONE, 11'd0, 1'b0, 8'd0, 4'd0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(OP_UNUSED, 11'd2047, 1'b1, 8'hff, 4'd15, 1'b1, 1'b1, 1'b1));
    send_item(make_item(OP_READ_BYTE, 11'd1, 1'b0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_DONE, 11'd0, 1'b0, 8'd0, 4'd0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(OP_WRITE_BYTE, CV_CONFIG, 1'b0, 8'hff, 4'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_DONE, 11'd0, 1'b0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_DONE, 11'd0, 1'b0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_READ_BIT, 11'd1, 1'b0, 8'd0, 4'd8, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_WRITE_BIT, 11'd1024, 1'b0, 8'd0, 4'd15, 1'b1, 1'b0, 1'b0));
    // bit write: miss, hit at 1, write, verify
    send_item(make_item(OP_WRITE_BIT, 11'd7, 1'b0, 8'd0, 4'd7, 1'b1, 1'b0, 1'b0));
    send_item(make_item(OP_DONE, 11'd0, 1'b0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_DONE, 11'd0, 1'b0, 8'd0, 4'd0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(OP_DONE, 11'd0, 1'b0, 8'd0, 4'd0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(OP_DONE, 11'd0, 1'b0, 8'd0, 4'd0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(OP_READ_BIT, CV_ACC_ADDR_LOW, 1'b1, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_DONE, 11'd0, 1'b0, 8'd0, 4'd0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(OP_VERIFY, CV_ACC_ADDR_HIGH, 1'b1, 8'ha5, 4'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_DONE, 11'd0, 1'b0, 8'd0, 4'd0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(OP_FACTORY, 11'd0, 1'b0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_DONE, 11'd0, 1'b0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_FACTORY, 11'd0, 1'b0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b1));
    send_item(make_item(OP_READ_BYTE, 11'd1024, 1'b0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_READ_BYTE, 11'd1, 1'b1, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0));
    // start while busy, then the primitive turns the next command down
    send_item(make_item(OP_READ_BYTE, 11'd8, 1'b0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_WRITE_BYTE, 11'd2, 1'b0, 8'h5a, 4'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(OP_DONE, 11'd0, 1'b0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b1));
    drain();

    // random part
    target = items_sent + RANDOM_ITEMS;
    ops = 0;
    while (items_sent < target) begin
      quiet <= (items_sent >= 600 && items_sent < 900);
      run_operation(ops == 3);
      if (ops % 20 == 19) drain();
      ops++;
    end
    quiet <= 1'b0;
    drain();
    repeat (4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS register_mode_cv_programming_sequencer_top");
    end else begin
      $display("FAIL register_mode_cv_programming_sequencer_top");
    end
    $finish;
  end

endmodule
